// ===== hw/rtl/pfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam logic [7:0] PIN_COUNT = 8'hFF;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_INCREF    = 3'd1,
    OP_DECREF    = 3'd2,
    OP_MARK_USED = 3'd3,
    OP_MARK_FREE = 3'd4,
    OP_QUERY     = 3'd5,
    OP_SEAL      = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] page_addr;
    logic [7:0]  ref_count;
    logic [12:0] free_pages;
    logic        done_ok;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic last;
    logic clear_last;
  } status_t;

endpackage

// ===== hw/rtl/pfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/pfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_datapath
// Page table memory, cursor, free-page counter and result registers.
// ----------------------------------------------------------------------------
module pfa_datapath #(
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfa_pkg::in_item_t   in_data_i,
  input  pfa_pkg::cmd_t       cmd_i,
  output pfa_pkg::status_t    status_o,
  output pfa_pkg::out_item_t  out_data_o
);
  import pfa_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int LW  = $clog2(NUM_PAGES + 1);
  localparam int PSH = $clog2(PAGE_BYTES);

  op_e            op_q;
  logic [PW-1:0]  cursor_q, cursor_d;
  logic [LW-1:0]  limit_q;
  logic [LW-1:0]  free_q, free_d;
  logic [31:0]    res_addr_q, res_addr_d;
  logic [7:0]     res_cnt_q, res_cnt_d;
  logic           ok_q, ok_d;
  out_item_t      out_q;

  op_e            in_op;
  logic [31:0]    in_page, end_sum, end_page;
  logic           in_range, range_empty;
  logic [LW-1:0]  in_limit, cur_inc;

  logic           we;
  logic [8:0]     wdata, rdata;
  logic           rd_used;
  logic [7:0]     rd_cnt, dec_cnt;
  logic           last;

  assign in_op       = op_e'(in_data_i.op);
  assign in_page     = in_data_i.addr >> PSH;
  assign in_range    = in_page < 32'(NUM_PAGES);
  assign end_sum     = in_data_i.addr + in_data_i.length + 32'(PAGE_BYTES - 1);
  assign end_page    = end_sum >> PSH;
  assign range_empty = !in_range || (in_page >= end_page);
  assign in_limit    = (end_page < 32'(NUM_PAGES)) ? LW'(end_page) : LW'(NUM_PAGES);

  always_comb begin
    unique case (in_op)
      OP_ALLOC:                  status_o.early = (free_q == '0);
      OP_INCREF, OP_DECREF,
      OP_QUERY:                  status_o.early = !in_range;
      OP_MARK_USED, OP_MARK_FREE: status_o.early = range_empty;
      OP_SEAL:                   status_o.early = 1'b0;
      default:                   status_o.early = 1'b1;
    endcase
  end

  assign status_o.clear_last = (cursor_q == PW'(NUM_PAGES - 1));
  assign status_o.last       = last;

  assign rd_used = rdata[8];
  assign rd_cnt  = rdata[7:0];
  assign dec_cnt = rd_cnt - 8'd1;
  assign cur_inc = LW'(cursor_q) + LW'(1);

  always_comb begin
    we         = 1'b0;
    wdata      = rdata;
    free_d     = free_q;
    res_addr_d = res_addr_q;
    res_cnt_d  = res_cnt_q;
    ok_d       = ok_q;
    last       = 1'b1;
    if (cmd_i.clear) begin
      we    = 1'b1;
      wdata = {1'b1, PIN_COUNT};
    end else if (cmd_i.accept) begin
      res_addr_d = '0;
      res_cnt_d  = '0;
      ok_d       = 1'b0;
    end else if (cmd_i.update) begin
      unique case (op_q)
        OP_ALLOC: begin
          last = !rd_used;
          if (!rd_used) begin
            we         = 1'b1;
            wdata      = {1'b1, 8'd1};
            free_d     = free_q - LW'(1);
            res_addr_d = 32'(cursor_q) << PSH;
            ok_d       = 1'b1;
          end
        end
        OP_INCREF: begin
          if (rd_cnt != PIN_COUNT) begin
            we    = 1'b1;
            wdata = {rd_used | (rd_cnt == 8'd0), rd_cnt + 8'd1};
            if (rd_cnt == 8'd0 && !rd_used) begin
              free_d = free_q - LW'(1);
            end
            ok_d = 1'b1;
          end
        end
        OP_DECREF: begin
          if (rd_cnt != PIN_COUNT && rd_cnt != 8'd0) begin
            we    = 1'b1;
            wdata = {rd_used & (dec_cnt != 8'd0), dec_cnt};
            if (dec_cnt == 8'd0 && rd_used) begin
              free_d = free_q + LW'(1);
            end
            ok_d = 1'b1;
          end
        end
        OP_MARK_USED: begin
          last  = cur_inc >= limit_q;
          we    = 1'b1;
          wdata = {1'b1, rd_cnt};
          if (!rd_used) begin
            free_d = free_q - LW'(1);
          end
          ok_d = 1'b1;
        end
        OP_MARK_FREE: begin
          last  = cur_inc >= limit_q;
          we    = 1'b1;
          wdata = {1'b0, 8'd0};
          if (rd_used) begin
            free_d = free_q + LW'(1);
          end
          ok_d = 1'b1;
        end
        OP_QUERY: begin
          res_cnt_d = rd_cnt;
          ok_d      = 1'b1;
        end
        OP_SEAL: begin
          last = status_o.clear_last;
          if (rd_used) begin
            we    = 1'b1;
            wdata = {1'b1, PIN_COUNT};
          end
          ok_d = 1'b1;
        end
        default: begin
          last = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.clear) begin
      cursor_d = status_o.clear_last ? '0 : cursor_q + PW'(1);
    end else if (cmd_i.accept) begin
      cursor_d = (in_op == OP_ALLOC || in_op == OP_SEAL) ? '0 : PW'(in_page);
    end else if (cmd_i.update && !last) begin
      cursor_d = cursor_q + PW'(1);
    end
  end

  pfa_ram #(
    .WIDTH (9),
    .DEPTH (NUM_PAGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cursor_q),
    .wdata_i (wdata),
    .raddr_i (cursor_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      free_q   <= '0;
    end else begin
      cursor_q <= cursor_d;
      free_q   <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= in_op;
      limit_q <= in_limit;
    end
    res_addr_q <= res_addr_d;
    res_cnt_q  <= res_cnt_d;
    ok_q       <= ok_d;
    if (cmd_i.load_out) begin
      out_q.page_addr  <= res_addr_q;
      out_q.ref_count  <= res_cnt_q;
      out_q.free_pages <= 13'(free_q);
      out_q.done_ok    <= ok_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/pfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer for clearing, page walks and the result handshake.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pfa_pkg::status_t  status_i,
  output pfa_pkg::cmd_t     cmd_o
);
  import pfa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (status_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = status_i.early ? ST_DONE : ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = status_i.last ? ST_DONE : ST_READ;
      ST_DONE:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.clear    = (state_q == ST_CLEAR);
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update   = (state_q == ST_UPDATE);
    cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    in_stall_o     = (state_q != ST_IDLE);
    out_valid_o    = out_valid_q;
    out_valid_d    = cmd_o.load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && status_i.early) |=> (state_q == ST_DONE))
    else $error("early item did not go to done");

  a_rose_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result shown without done state");

  a_update_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> $past(state_q == ST_READ))
    else $error("update without read");

endmodule

// ===== hw/rtl/page_frame_allocator_refcount.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame allocator with per-page used bit and 8-bit reference count.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_PAGES pages that
// marks every page used and pinned; no item is taken during it. Each page
// lives in one memory word that is read and then written, so every page
// visited takes a read state and an update state. Increment, decrement and
// query visit the one page in range, allocate walks up from page 0 to the
// lowest free page, a range op visits the pages touched and seal visits every
// page; a page out of range, an empty range, an allocate with no free page or
// the unused op code go straight to the done state. One item is in work at a
// time; the result register lets the next item in while a result waits.
module page_frame_allocator_refcount #(
  parameter int NUM_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pfa_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pfa_pkg::out_item_t  out_data_o
);
  import pfa_pkg::*;

  cmd_t    cmd;
  status_t status;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
